// File: hw/rtl/oll_pkg.sv
// oll_pkg: sizes, types and command codes of the ordered label list
// no dependencies; imported by the top level

package oll_pkg;

    localparam int CAPACITY   = 16;
    localparam int LABEL_BITS = 16;

    localparam int CMD_W   = 4;
    localparam int INDEX_W = 4;
    localparam int LABEL_W = 16;
    localparam int VALUE_W = 16;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef logic [IDX_W-1:0]      addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LABEL_BITS-1:0] lab_t;
    typedef logic [CMD_W-1:0]      cmd_t;

    localparam cmd_t CMD_PUSH_FRONT   = 4'd0;
    localparam cmd_t CMD_APPEND       = 4'd1;
    localparam cmd_t CMD_INSERT       = 4'd2;
    localparam cmd_t CMD_DELETE_AT    = 4'd3;
    localparam cmd_t CMD_PULL         = 4'd4;
    localparam cmd_t CMD_POP          = 4'd5;
    localparam cmd_t CMD_GET          = 4'd6;
    localparam cmd_t CMD_FIRST        = 4'd7;
    localparam cmd_t CMD_LAST         = 4'd8;
    localparam cmd_t CMD_UPDATE_AT    = 4'd9;
    localparam cmd_t CMD_UPDATE_FIRST = 4'd10;
    localparam cmd_t CMD_UPDATE_LAST  = 4'd11;
    localparam cmd_t CMD_DELETE_VALUE = 4'd12;
    localparam cmd_t CMD_CONTAINS     = 4'd13;
    localparam cmd_t CMD_CLEAR        = 4'd14;

endpackage

// File: hw/rtl/oll_ram.sv
// oll_ram: generic single-write, single-read synchronous RAM
// read data is registered; no dependencies

module oll_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/ordered_label_list.sv
// Ordered label list: a bounded list of up to CAPACITY labels in one RAM.
// A request is taken when start is high and busy is low. Commands that touch
// at most one entry without reading it (append, update, clear, any failing
// command) keep busy low and give their result in the next cycle.
// Get, first, last and pop read one entry and are busy in S_READ; the result
// is registered from the RAM read data. Insert and push front onto a
// non-empty list walk the entries from the back down to the insert point, one
// entry per cycle, then write the label. Delete at index and pull walk from
// the index (the front for pull) to the back; delete by value and contains
// walk from the front. The walk is set by the single RAM read port, one entry
// per cycle. The result is shown for exactly one cycle with done high; ok and
// value hold until the next request is taken.
// Depends on oll_pkg and oll_ram.

module ordered_label_list
    import oll_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [INDEX_W-1:0] index,
    input  logic [LABEL_W-1:0] label,
    output logic               done,
    output logic               ok,
    output logic [VALUE_W-1:0] value,
    output logic [CNT_W-1:0]   count_now
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_SHR  = 3'd2;
    localparam logic [2:0] S_WLAB = 3'd3;
    localparam logic [2:0] S_HEAD = 3'd4;
    localparam logic [2:0] S_SHL  = 3'd5;
    localparam logic [2:0] S_SRCH = 3'd6;

    logic [2:0]         state_reg, state_next;
    cnt_t               count_reg, count_next;
    logic               done_reg, done_next;
    logic               ok_reg, ok_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    addr_t              rp_reg, rp_next;
    addr_t              pos_reg, pos_next;
    lab_t               lab_reg, lab_next;
    cmd_t               cmd_reg, cmd_next;

    logic               ram_we;
    addr_t              ram_waddr;
    lab_t               ram_wdata;
    logic               ram_re;
    addr_t              ram_raddr;
    lab_t               ram_rdata;

    lab_t               lab_in;
    addr_t              idx_addr;
    addr_t              last_addr;
    addr_t              cnt_addr;
    logic               in_range;
    logic               full;
    logic               empty;
    logic               ins_legal;
    addr_t              ins_pos;

    oll_ram #(
        .WIDTH (LABEL_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign lab_in    = label[LABEL_BITS-1:0];
    assign idx_addr  = IDX_W'(index);
    assign last_addr = IDX_W'(count_reg - 1'b1);
    assign cnt_addr  = IDX_W'(count_reg);
    assign in_range  = CMP_W'(index) < CMP_W'(count_reg);
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign empty     = count_reg == '0;
    assign busy      = state_reg != S_IDLE;

    always_comb
    begin
        ins_legal = 1'b0;
        ins_pos   = '0;
        case (cmd)
            CMD_PUSH_FRONT:
            begin
                ins_legal = !full;
                ins_pos   = '0;
            end
            CMD_APPEND:
            begin
                ins_legal = !full;
                ins_pos   = cnt_addr;
            end
            CMD_INSERT:
            begin
                ins_legal = !full && in_range;
                ins_pos   = idx_addr;
            end
            default:
            begin
                ins_legal = 1'b0;
                ins_pos   = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        value_next = value_reg;
        rp_next    = rp_reg;
        pos_next   = pos_reg;
        lab_next   = lab_reg;
        cmd_next   = cmd_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = lab_reg;
        ram_re     = 1'b0;
        ram_raddr  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    lab_next = lab_in;
                    // failing requests finish at once with ok low and value zero
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    value_next = '0;
                    case (cmd)
                        CMD_PUSH_FRONT, CMD_APPEND, CMD_INSERT:
                        begin
                            if (ins_legal)
                            begin
                                if (ins_pos == cnt_addr)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = cnt_addr;
                                    ram_wdata  = lab_in;
                                    ok_next    = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    // open a gap: walk from the back down
                                    done_next  = 1'b0;
                                    ram_re     = 1'b1;
                                    ram_raddr  = last_addr;
                                    rp_next    = last_addr;
                                    pos_next   = ins_pos;
                                    state_next = S_SHR;
                                end
                            end
                        end
                        CMD_DELETE_AT, CMD_PULL:
                        begin
                            if ((cmd == CMD_DELETE_AT) ? in_range : !empty)
                            begin
                                done_next  = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = (cmd == CMD_DELETE_AT) ? idx_addr : '0;
                                rp_next    = ram_raddr;
                                state_next = S_HEAD;
                            end
                        end
                        CMD_POP, CMD_FIRST, CMD_LAST, CMD_GET:
                        begin
                            if ((cmd == CMD_GET) ? in_range : !empty)
                            begin
                                done_next  = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = (cmd == CMD_GET)   ? idx_addr :
                                             (cmd == CMD_FIRST) ? '0 : last_addr;
                                state_next = S_READ;
                            end
                        end
                        CMD_UPDATE_AT, CMD_UPDATE_FIRST, CMD_UPDATE_LAST:
                        begin
                            if ((cmd == CMD_UPDATE_AT) ? in_range : !empty)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = (cmd == CMD_UPDATE_AT)    ? idx_addr :
                                            (cmd == CMD_UPDATE_FIRST) ? '0 : last_addr;
                                ram_wdata = lab_in;
                                ok_next   = 1'b1;
                            end
                        end
                        CMD_DELETE_VALUE, CMD_CONTAINS:
                        begin
                            if (!empty)
                            begin
                                done_next  = 1'b0;
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                rp_next    = '0;
                                state_next = S_SRCH;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                done_next  = 1'b1;
                ok_next    = 1'b1;
                value_next = VALUE_W'(ram_rdata);
                if (cmd_reg == CMD_POP)
                begin
                    count_next = count_reg - 1'b1;
                end
                state_next = S_IDLE;
            end

            S_SHR:
            begin
                // data read last cycle moves one place back
                ram_we    = 1'b1;
                ram_waddr = rp_reg + 1'b1;
                ram_wdata = ram_rdata;
                if (rp_reg == pos_reg)
                begin
                    state_next = S_WLAB;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rp_reg - 1'b1;
                    rp_next   = rp_reg - 1'b1;
                end
            end

            S_WLAB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = lab_reg;
                done_next  = 1'b1;
                ok_next    = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_IDLE;
            end

            S_HEAD, S_SRCH:
            begin
                if (state_reg == S_HEAD || ram_rdata == lab_reg)
                begin
                    value_next = (state_reg == S_HEAD) ? VALUE_W'(ram_rdata) : '0;
                    if (cmd_reg == CMD_CONTAINS || rp_reg == last_addr)
                    begin
                        done_next  = 1'b1;
                        ok_next    = 1'b1;
                        if (cmd_reg != CMD_CONTAINS)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // close the gap: walk from the removed entry to the back
                        ram_re     = 1'b1;
                        ram_raddr  = rp_reg + 1'b1;
                        rp_next    = rp_reg + 1'b1;
                        state_next = S_SHL;
                    end
                end
                else if (rp_reg == last_addr)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    value_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rp_reg + 1'b1;
                    rp_next   = rp_reg + 1'b1;
                end
            end

            S_SHL:
            begin
                ram_we    = 1'b1;
                ram_waddr = rp_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (rp_reg == last_addr)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rp_reg + 1'b1;
                    rp_next   = rp_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        value_reg <= value_next;
        rp_reg    <= rp_next;
        pos_reg   <= pos_next;
        lab_reg   <= lab_next;
        cmd_reg   <= cmd_next;
    end

    assign done      = done_reg;
    assign ok        = ok_reg;
    assign value     = value_reg;
    assign count_now = count_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("result shown while a walk is still running");

    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> count_reg == $past(count_reg))
        else $error("failed request changed the count");

    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !ok_reg) |-> value_reg == '0)
        else $error("failed request returned a nonzero value");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> ram_waddr != ram_raddr)
        else $error("read and write of the same entry in one cycle");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != '0 && count_reg <= CNT_W'(CAPACITY)))
        else $error("walk started on an empty or overfull list");
`endif

endmodule
